// ===== rtl/core/wlsp_pkg.sv =====
`timescale 1ns / 1ps
// Types, register indexes, fault codes and CORDIC tables of the wall line block.
package wlsp_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_VALID        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELIABLE_RANGE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAIR_DIFF    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAR_ANGLE_LEFT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEAR_ANGLE_LEFT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAR_ANGLE_RIGHT  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEAR_ANGLE_RIGHT = 3'd6;

   localparam logic [1:0] FAULT_OK       = 2'd0;
   localparam logic [1:0] FAULT_RANGE    = 2'd1;
   localparam logic [1:0] FAULT_DIFF     = 2'd2;
   localparam logic [1:0] FAULT_COINCIDE = 2'd3;

   localparam logic [18:0] DIST_MAX = 19'd524287;
   localparam logic signed [33:0] GAIN_INV_Q30 = 34'sd652032874;

   localparam logic [31:0] ATAN_TURNS [24] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
   };

   typedef struct packed {
      logic        side;
      logic [15:0] far_reading;
      logic [15:0] near_reading;
   } req_payload_type;

   typedef struct packed {
      logic               side_out;
      logic               wall_valid;
      logic [1:0]         fault;
      logic [18:0]        wall_distance;
      logic signed [15:0] wall_angle;
   } rsp_payload_type;

   typedef struct packed {
      logic       side;
      logic [1:0] fault;
      logic       flat;
   } meta_type;

endpackage

// ===== rtl/core/wlsp_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream channel with a typed payload.
interface wlsp_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/wall_line_from_sensor_pair.sv =====
`timescale 1ns / 1ps
// Wall line from a sensor pair: range checks, polar-to-x/y CORDIC, distance and wall angle.
//
// Takes one reading pair per clock and returns one result per item in order.
// Its pipeline holds the rotation CORDIC and, after it, the 32-step square
// root of the squared line length and the (15 + FRACTION_BITS)-step
// restoring divider.
// The whole pipeline holds while a result waits at the output; req ready is
// low only then. Configuration writes take effect at once and belong to idle
// periods.
module wall_line_from_sensor_pair #(
   parameter int CORDIC_STAGES = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   wlsp_chan_if.sink   req_chan,
   wlsp_chan_if.source rsp_chan,
   input  logic                                csr_we,
   input  logic [wlsp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wlsp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int N   = CORDIC_STAGES;
   localparam int F   = FRACTION_BITS;
   localparam int TW  = 34;
   localparam int ZW  = 33;
   localparam int CW  = 18 + F;
   localparam int DW  = CW + 1;
   localparam int PW  = 2 * CW;
   localparam int SW  = 2 * DW + 1;
   localparam int VW  = 44;
   localparam int QB  = 15 + F;
   localparam int SH  = F - 4;
   localparam int RND = (SH > 0) ? (1 << (SH - 1)) : 0;

   localparam longint unsigned CO_LIM = ((64'd1 << (2 * F)) + 64'd999999) / 64'd1000000;
   localparam int FL_LIM = ((1 << F) + 999) / 1000;
   localparam logic signed [TW+16:0] COORD_RND = (TW + 17)'(1) << (29 - F);

   localparam int S_COORD = 6 + N;
   localparam int S_DIFF  = 7 + N;
   localparam int S_SQ    = 8 + N;
   localparam int S_SUM   = 9 + N;
   localparam int S_OUT   = 44 + N + QB;
   localparam int LAT     = S_OUT + 1;
   localparam int ANG_DLY = 32 + QB - N;

   function automatic logic [15:0] wrap_angle(input logic signed [15:0] a);
      logic signed [16:0] t;
      t = 17'(a) + 17'sd36000;
      return a[15] ? t[15:0] : a;
   endfunction

   function automatic logic signed [CW-1:0] to_coord(input logic [15:0] d,
                                                    input logic signed [TW-1:0] t);
      logic signed [TW+16:0] p;
      p = $signed({1'b0, d}) * t;
      p = (p + COORD_RND) >>> (30 - F);
      return p[CW-1:0];
   endfunction

   // flow control
   logic [LAT-1:0] vld_ff;
   logic           ce;

   assign ce             = !vld_ff[LAT-1] || rsp_chan.ready;
   assign req_chan.ready = ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[LAT-2:0], req_chan.valid};
      end
   end

   // configuration registers
   logic [14:0]        min_valid_ff, reliable_ff, max_diff_ff;
   logic signed [15:0] far_left_ff, near_left_ff, far_right_ff, near_right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_valid_ff  <= 15'd30;
         reliable_ff   <= 15'd1200;
         max_diff_ff   <= 15'd500;
         far_left_ff   <= -16'sd7000;
         near_left_ff  <= -16'sd2000;
         far_right_ff  <= 16'sd7000;
         near_right_ff <= 16'sd2000;
      end else if (csr_we) begin
         unique case (csr_index)
            wlsp_pkg::CSR_MIN_VALID:        min_valid_ff  <= csr_wdata[14:0];
            wlsp_pkg::CSR_RELIABLE_RANGE:   reliable_ff   <= csr_wdata[14:0];
            wlsp_pkg::CSR_MAX_PAIR_DIFF:    max_diff_ff   <= csr_wdata[14:0];
            wlsp_pkg::CSR_FAR_ANGLE_LEFT:   far_left_ff   <= csr_wdata;
            wlsp_pkg::CSR_NEAR_ANGLE_LEFT:  near_left_ff  <= csr_wdata;
            wlsp_pkg::CSR_FAR_ANGLE_RIGHT:  far_right_ff  <= csr_wdata;
            wlsp_pkg::CSR_NEAR_ANGLE_RIGHT: near_right_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline registers
   wlsp_pkg::meta_type meta_ff [LAT-1];
   wlsp_pkg::meta_type meta_in;
   logic [15:0]        rdf_ff [S_COORD];
   logic [15:0]        rdn_ff [S_COORD];

   logic [15:0]        am_ff  [2];
   logic [31:0]        hi_ff  [2];
   logic [24:0]        m_ff   [2];
   logic [31:0]        h2_ff  [2];
   logic [14:0]        q2_ff  [2];
   logic [31:0]        ph_ff  [2];

   logic signed [TW-1:0] rx_ff [2][N+1];
   logic signed [TW-1:0] ry_ff [2][N+1];
   logic signed [ZW-1:0] rz_ff [2][N+1];
   logic [1:0]           rq_ff [2][N+1];
   logic signed [TW-1:0] rx_in [2][N+1];
   logic signed [TW-1:0] ry_in [2][N+1];
   logic signed [ZW-1:0] rz_in [2][N+1];
   logic [31:0]          ph_sum [2];
   logic [31:0]          ph_ru  [2];

   logic signed [TW-1:0] sn_ff [2];
   logic signed [TW-1:0] cs_ff [2];
   logic signed [TW-1:0] sn_in [2];
   logic signed [TW-1:0] cs_in [2];

   logic signed [CW-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic signed [DW-1:0] dx_ff, dy_ff;
   logic [63:0]          p1_ff, p2_ff;
   logic signed [PW+63:0] p1w, p2w;

   logic [DW-1:0]        ux, uy;
   logic [2*DW-1:0]      sqx_ff, sqy_ff;
   logic [63:0]          cu_ff;
   logic                 flat_in;

   logic [SW+63:0]       sumx;
   logic [63:0]          l2_in;
   logic                 coinc_in;

   logic [63:0]          sv_ff [33];
   logic [63:0]          sr_ff [33];
   logic [63:0]          sc_ff [33];
   logic [63:0]          sv_in [33];
   logic [63:0]          sr_in [33];

   logic [64:0]          n_ff;
   logic [31:0]          len_ff;
   logic [64:0]          n_hi;

   logic [31:0]          dr_ff [QB+1];
   logic [QB-1:0]        dl_ff [QB+1];
   logic [QB-1:0]        dq_ff [QB+1];
   logic                 ds_ff [QB+1];
   logic [31:0]          dn_ff [QB+1];
   logic [31:0]          dr_in [QB+1];
   logic [QB-1:0]        dq_in [QB+1];
   logic [32:0]          div_rs [QB+1];
   logic                 div_ge [QB+1];

   logic signed [DW:0]   ax_ff, ay_ff, ax2_ff, ay2_ff;
   logic [31:0]          az_ff, az2_ff;
   logic [DW:0]          amag;
   logic [5:0]           msb_pos;
   logic [5:0]           nsh_ff;

   logic signed [VW-1:0] vx_ff [N+1];
   logic signed [VW-1:0] vy_ff [N+1];
   logic [31:0]          vz_ff [N+1];
   logic signed [VW-1:0] vx_in [N+1];
   logic signed [VW-1:0] vy_in [N+1];
   logic [31:0]          vz_in [N+1];
   logic                 vy_pos [N+1];

   logic signed [47:0]   cp_ff;
   logic signed [47:0]   cp_rnd;
   logic signed [15:0]   ang_ff [ANG_DLY];

   logic [QB:0]          qd_round;
   logic [18:0]          dist_in;
   wlsp_pkg::rsp_payload_type out_ff, out_in;

   always_comb begin
      // input checks
      meta_in.side = req_chan.payload.side;
      meta_in.flat = 1'b0;
      if (req_chan.payload.far_reading < {1'b0, min_valid_ff} ||
          req_chan.payload.far_reading > {1'b0, reliable_ff} ||
          req_chan.payload.near_reading < {1'b0, min_valid_ff} ||
          req_chan.payload.near_reading > {1'b0, reliable_ff}) begin
         meta_in.fault = wlsp_pkg::FAULT_RANGE;
      end else if (((req_chan.payload.far_reading > req_chan.payload.near_reading) ?
                    req_chan.payload.far_reading - req_chan.payload.near_reading :
                    req_chan.payload.near_reading - req_chan.payload.far_reading)
                   > {1'b0, max_diff_ff}) begin
         meta_in.fault = wlsp_pkg::FAULT_DIFF;
      end else begin
         meta_in.fault = wlsp_pkg::FAULT_OK;
      end

      // phase fold and rotation CORDIC, far and near in parallel
      for (int f = 0; f < 2; f++) begin
         ph_sum[f] = ph_ff[f] + 32'h2000_0000;
         ph_ru[f]  = ph_ff[f] - {ph_sum[f][31:30], 30'd0};
         rx_in[f][0] = wlsp_pkg::GAIN_INV_Q30;
         ry_in[f][0] = '0;
         rz_in[f][0] = ZW'($signed(ph_ru[f]));
         for (int i = 0; i < N; i++) begin
            if (!rz_ff[f][i][ZW-1]) begin
               rx_in[f][i+1] = rx_ff[f][i] - (ry_ff[f][i] >>> i);
               ry_in[f][i+1] = ry_ff[f][i] + (rx_ff[f][i] >>> i);
               rz_in[f][i+1] = rz_ff[f][i] - $signed({1'b0, wlsp_pkg::ATAN_TURNS[i]});
            end else begin
               rx_in[f][i+1] = rx_ff[f][i] + (ry_ff[f][i] >>> i);
               ry_in[f][i+1] = ry_ff[f][i] - (rx_ff[f][i] >>> i);
               rz_in[f][i+1] = rz_ff[f][i] + $signed({1'b0, wlsp_pkg::ATAN_TURNS[i]});
            end
         end
         case (rq_ff[f][N])
            2'd0: begin
               cs_in[f] = rx_ff[f][N];
               sn_in[f] = ry_ff[f][N];
            end
            2'd1: begin
               cs_in[f] = -ry_ff[f][N];
               sn_in[f] = rx_ff[f][N];
            end
            2'd2: begin
               cs_in[f] = -rx_ff[f][N];
               sn_in[f] = -ry_ff[f][N];
            end
            default: begin
               cs_in[f] = ry_ff[f][N];
               sn_in[f] = -rx_ff[f][N];
            end
         endcase
      end

      // line terms
      p1w = x1_ff * y2_ff;
      p2w = x2_ff * y1_ff;
      ux = dx_ff[DW-1] ? DW'(-dx_ff) : DW'(dx_ff);
      uy = dy_ff[DW-1] ? DW'(-dy_ff) : DW'(dy_ff);
      flat_in = uy < DW'(FL_LIM);
      sumx = (SW + 64)'(sqx_ff) + (SW + 64)'(sqy_ff);
      l2_in = (|sumx[SW+63:64]) ? '1 : sumx[63:0];
      coinc_in = l2_in < CO_LIM;

      // floor square root, one result bit per stage
      sv_in[0] = l2_in;
      sr_in[0] = '0;
      for (int k = 1; k <= 32; k++) begin
         if (sv_ff[k-1] >= sr_ff[k-1] + (64'd1 << (64 - 2 * k))) begin
            sv_in[k] = sv_ff[k-1] - (sr_ff[k-1] + (64'd1 << (64 - 2 * k)));
            sr_in[k] = (sr_ff[k-1] >> 1) + (64'd1 << (64 - 2 * k));
         end else begin
            sv_in[k] = sv_ff[k-1];
            sr_in[k] = sr_ff[k-1] >> 1;
         end
      end

      // restoring divider
      n_hi = n_ff >> QB;
      div_rs[0] = '0;
      div_ge[0] = n_hi >= 65'(len_ff);
      dr_in[0] = div_ge[0] ? '0 : n_hi[31:0];
      dq_in[0] = '0;
      for (int j = 1; j <= QB; j++) begin
         div_rs[j] = {dr_ff[j-1], dl_ff[j-1][QB-1]};
         div_ge[j] = div_rs[j] >= {1'b0, dn_ff[j-1]};
         dr_in[j] = div_ge[j] ? 32'(div_rs[j] - {1'b0, dn_ff[j-1]}) : div_rs[j][31:0];
         dq_in[j] = {dq_ff[j-1][QB-2:0], div_ge[j]};
      end

      // angle: normalize then vectoring CORDIC
      amag = ax_ff | (ay_ff[DW] ? (DW + 1)'(-ay_ff) : (DW + 1)'(ay_ff));
      msb_pos = '0;
      for (int b = 0; b < DW + 1; b++) begin
         if (amag[b]) msb_pos = 6'(b);
      end
      vx_in[0] = VW'(ax2_ff) <<< nsh_ff;
      vy_in[0] = VW'(ay2_ff) <<< nsh_ff;
      vz_in[0] = az2_ff;
      vy_pos[0] = 1'b0;
      for (int i = 0; i < N; i++) begin
         vy_pos[i+1] = !vy_ff[i][VW-1] && (vy_ff[i] != '0);
         if (vy_pos[i+1]) begin
            vx_in[i+1] = vx_ff[i] + (vy_ff[i] >>> i);
            vy_in[i+1] = vy_ff[i] - (vx_ff[i] >>> i);
            vz_in[i+1] = vz_ff[i] + wlsp_pkg::ATAN_TURNS[i];
         end else begin
            vx_in[i+1] = vx_ff[i] - (vy_ff[i] >>> i);
            vy_in[i+1] = vy_ff[i] + (vx_ff[i] >>> i);
            vz_in[i+1] = vz_ff[i] - wlsp_pkg::ATAN_TURNS[i];
         end
      end
      cp_rnd = (cp_ff + 48'sd2147483648) >>> 32;

      // result
      qd_round = ((QB + 1)'(dq_ff[QB]) + (QB + 1)'(RND)) >> SH;
      dist_in = (ds_ff[QB] || qd_round > (QB + 1)'(wlsp_pkg::DIST_MAX)) ?
                wlsp_pkg::DIST_MAX : qd_round[18:0];
      out_in.side_out   = meta_ff[LAT-2].side;
      out_in.fault      = meta_ff[LAT-2].fault;
      out_in.wall_valid = meta_ff[LAT-2].fault == wlsp_pkg::FAULT_OK;
      out_in.wall_distance = out_in.wall_valid ? dist_in : '0;
      out_in.wall_angle = (out_in.wall_valid && !meta_ff[LAT-2].flat) ?
                          ang_ff[ANG_DLY-1] : '0;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         meta_ff[0] <= meta_in;
         for (int k = 1; k < LAT - 1; k++) begin
            if (k == S_SQ) begin
               meta_ff[k] <= '{side: meta_ff[k-1].side, fault: meta_ff[k-1].fault,
                               flat: flat_in};
            end else if (k == S_SUM && meta_ff[k-1].fault == wlsp_pkg::FAULT_OK &&
                         coinc_in) begin
               meta_ff[k] <= '{side: meta_ff[k-1].side, fault: wlsp_pkg::FAULT_COINCIDE,
                               flat: meta_ff[k-1].flat};
            end else begin
               meta_ff[k] <= meta_ff[k-1];
            end
         end
         rdf_ff[0] <= req_chan.payload.far_reading;
         rdn_ff[0] <= req_chan.payload.near_reading;
         for (int k = 1; k < S_COORD; k++) begin
            rdf_ff[k] <= rdf_ff[k-1];
            rdn_ff[k] <= rdn_ff[k-1];
         end

         // angle to turns: phase = a*119304 + floor((a*728 + 562) / 1125)
         am_ff[0] <= wrap_angle(req_chan.payload.side ? far_right_ff : far_left_ff);
         am_ff[1] <= wrap_angle(req_chan.payload.side ? near_right_ff : near_left_ff);
         for (int f = 0; f < 2; f++) begin
            hi_ff[f] <= 32'(am_ff[f]) * 32'd119304;
            m_ff[f]  <= 25'(am_ff[f]) * 25'd728 + 25'd562;
            h2_ff[f] <= hi_ff[f];
            q2_ff[f] <= 15'((50'(m_ff[f]) * 50'd30541990) >> 35);
            ph_ff[f] <= h2_ff[f] + 32'(q2_ff[f]);
            rq_ff[f][0] <= ph_sum[f][31:30];
            for (int i = 0; i <= N; i++) begin
               rx_ff[f][i] <= rx_in[f][i];
               ry_ff[f][i] <= ry_in[f][i];
               rz_ff[f][i] <= rz_in[f][i];
               if (i > 0) rq_ff[f][i] <= rq_ff[f][i-1];
            end
            sn_ff[f] <= sn_in[f];
            cs_ff[f] <= cs_in[f];
         end

         x1_ff <= to_coord(rdf_ff[S_COORD-1], sn_ff[0]);
         y1_ff <= to_coord(rdf_ff[S_COORD-1], cs_ff[0]);
         x2_ff <= to_coord(rdn_ff[S_COORD-1], sn_ff[1]);
         y2_ff <= to_coord(rdn_ff[S_COORD-1], cs_ff[1]);

         dx_ff <= DW'(x2_ff) - DW'(x1_ff);
         dy_ff <= DW'(y2_ff) - DW'(y1_ff);
         p1_ff <= p1w[63:0];
         p2_ff <= p2w[63:0];

         sqx_ff <= (2 * DW)'(ux) * (2 * DW)'(ux);
         sqy_ff <= (2 * DW)'(uy) * (2 * DW)'(uy);
         cu_ff  <= p1_ff - p2_ff;

         sc_ff[0] <= cu_ff[63] ? -cu_ff : cu_ff;
         for (int k = 0; k <= 32; k++) begin
            sv_ff[k] <= sv_in[k];
            sr_ff[k] <= sr_in[k];
            if (k > 0) sc_ff[k] <= sc_ff[k-1];
         end

         n_ff   <= 65'(sc_ff[32]) + 65'(sr_ff[32][31:1]);
         len_ff <= sr_ff[32][31:0];

         dl_ff[0] <= n_ff[QB-1:0];
         ds_ff[0] <= div_ge[0];
         dn_ff[0] <= len_ff;
         for (int j = 0; j <= QB; j++) begin
            dr_ff[j] <= dr_in[j];
            dq_ff[j] <= dq_in[j];
            if (j > 0) begin
               dl_ff[j] <= dl_ff[j-1] << 1;
               ds_ff[j] <= ds_ff[j-1];
               dn_ff[j] <= dn_ff[j-1];
            end
         end

         // atan2(dx, dy): x axis is dy
         ax_ff <= dy_ff[DW-1] ? -(DW + 1)'(dy_ff) : (DW + 1)'(dy_ff);
         ay_ff <= dy_ff[DW-1] ? -(DW + 1)'(dx_ff) : (DW + 1)'(dx_ff);
         az_ff <= dy_ff[DW-1] ? 32'h8000_0000 : 32'h0;
         ax2_ff <= ax_ff;
         ay2_ff <= ay_ff;
         az2_ff <= az_ff;
         nsh_ff <= (msb_pos >= 6'd40) ? 6'd0 : 6'd40 - msb_pos;
         for (int i = 0; i <= N; i++) begin
            vx_ff[i] <= vx_in[i];
            vy_ff[i] <= vy_in[i];
            vz_ff[i] <= vz_in[i];
         end
         cp_ff <= 48'($signed(vz_ff[N])) * 48'sd36000;
         ang_ff[0] <= cp_rnd[15:0];
         for (int k = 1; k < ANG_DLY; k++) begin
            ang_ff[k] <= ang_ff[k-1];
         end

         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid   = vld_ff[LAT-1];
   assign rsp_chan.payload = out_ff;

   a_flag_matches_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         (rsp_chan.payload.wall_valid == (rsp_chan.payload.fault == wlsp_pkg::FAULT_OK)))
      else $error("wall_valid disagrees with fault code");

   a_fault_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.payload.wall_valid) |->
         (rsp_chan.payload.wall_distance == '0 && rsp_chan.payload.wall_angle == '0))
      else $error("faulted result carries a distance or angle");

   a_stall_only_at_output: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready))
      else $error("input held off without an output stall");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=> $stable(out_ff) && rsp_chan.valid)
      else $error("stalled result changed");

endmodule

// ===== test/tb_wall_line_from_sensor_pair.sv =====
`timescale 1ns / 1ps
// Testbench for wall_line_from_sensor_pair: directed and random reading pairs against a predictor.
module tb_wall_line_from_sensor_pair;

   typedef struct {
      bit                                 is_csr;
      logic [wlsp_pkg::CSR_INDEX_W-1:0]   idx;
      logic [15:0]                        val;
      wlsp_pkg::req_payload_type          req;
      bit                                 typed;
      logic [1:0]                         fault;
   } dir_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [wlsp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [wlsp_pkg::CSR_DATA_W-1:0]  csr_wdata;

   wlsp_chan_if #(.payload_type(wlsp_pkg::req_payload_type)) req_chan ();
   wlsp_chan_if #(.payload_type(wlsp_pkg::rsp_payload_type)) rsp_chan ();

   wall_line_from_sensor_pair u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   int unsigned min_mm, max_mm, diff_mm;
   int far_l, near_l, far_r, near_r;
   wlsp_pkg::rsp_payload_type wall_q[$];
   bit typed_on;
   wlsp_pkg::rsp_payload_type typed_rsp;
   int n_err = 0;
   bit no_idle;
   int stall_cnt = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic longint unsigned mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic void sincos(input int h, output longint sn, output longint cs);
      int a;
      longint unsigned ph;
      bit [31:0] phase, q, ru;
      longint x, y, z, nx, ny;
      a = h % 36000;
      if (a < 0) a += 36000;
      ph = ((longint'(a) << 32) + 18000) / 36000;
      phase = ph[31:0];
      q = ((phase + 32'h2000_0000) >> 30) & 32'd3;
      ru = phase - (q << 30);
      z = signed'(ru);
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i);
            z = z - longint'(wlsp_pkg::ATAN_TURNS[i]);
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i);
            z = z + longint'(wlsp_pkg::ATAN_TURNS[i]);
         end
         x = nx; y = ny;
      end
      case (q)
         0: begin cs = x;  sn = y;  end
         1: begin cs = -y; sn = x;  end
         2: begin cs = -x; sn = -y; end
         default: begin cs = y; sn = -x; end
      endcase
   endfunction

   function automatic longint to_mm_q(int unsigned d, longint trig);
      return (longint'(d) * trig + 2097152) >>> 22;
   endfunction

   function automatic int heading(longint yv, longint xv);
      bit [31:0] z;
      longint nx, ny, s;
      z = 0;
      if (xv < 0) begin xv = -xv; yv = -yv; z = 32'h8000_0000; end
      while (mag(xv) < (64'd1 << 40) && mag(yv) < (64'd1 << 40)) begin
         xv = xv * 2; yv = yv * 2;
      end
      for (int i = 0; i < 16; i++) begin
         if (yv > 0) begin
            nx = xv + (yv >>> i); ny = yv - (xv >>> i); z = z + wlsp_pkg::ATAN_TURNS[i];
         end else begin
            nx = xv - (yv >>> i); ny = yv + (xv >>> i); z = z - wlsp_pkg::ATAN_TURNS[i];
         end
         xv = nx; yv = ny;
      end
      s = signed'(z);
      return int'((s * 36000 + 64'sh8000_0000) >>> 32);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin v = v - (r + b); r = (r >> 1) + b; end
         else r = r >> 1;
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic wlsp_pkg::rsp_payload_type wall_line(wlsp_pkg::req_payload_type rq);
      wlsp_pkg::rsp_payload_type o;
      int unsigned df, dn, dd;
      int af, an, ang;
      logic [1:0] flt;
      longint s1, c1, s2, c2, x1, y1, x2, y2, dx, dy;
      longint unsigned ux, uy, l2, sq, len, cu, cmag, qd, dist_q;
      df = rq.far_reading;
      dn = rq.near_reading;
      af = rq.side ? far_r : far_l;
      an = rq.side ? near_r : near_l;
      flt = wlsp_pkg::FAULT_OK;
      dist_q = 0;
      ang = 0;
      if (df < min_mm || df > max_mm || dn < min_mm || dn > max_mm) begin
         flt = wlsp_pkg::FAULT_RANGE;
      end else begin
         dd = df > dn ? df - dn : dn - df;
         if (dd > diff_mm) flt = wlsp_pkg::FAULT_DIFF;
      end
      if (flt == wlsp_pkg::FAULT_OK) begin
         sincos(af, s1, c1);
         sincos(an, s2, c2);
         x1 = to_mm_q(df, s1); y1 = to_mm_q(df, c1);
         x2 = to_mm_q(dn, s2); y2 = to_mm_q(dn, c2);
         dx = x2 - x1; dy = y2 - y1;
         ux = mag(dx); uy = mag(dy);
         l2 = ux * ux; sq = uy * uy;
         l2 = (l2 > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : l2 + sq;
         if (l2 < (64'd1 << 32) && l2 * 1000000 < 64'd65536) begin
            flt = wlsp_pkg::FAULT_COINCIDE;
         end else begin
            len = root_floor(l2);
            cu = x1 * y2 - x2 * y1;
            cmag = cu[63] ? -cu : cu;
            qd = len != 0 ? (cmag + len / 2) / len : 0;
            qd = (qd + 8) >> 4;
            dist_q = qd > wlsp_pkg::DIST_MAX ? wlsp_pkg::DIST_MAX : qd;
            if (uy * 1000 >= 256) ang = heading(dx, dy);
         end
      end
      o.side_out = rq.side;
      o.wall_valid = flt == wlsp_pkg::FAULT_OK;
      o.fault = flt;
      o.wall_distance = flt == wlsp_pkg::FAULT_OK ? dist_q[18:0] : '0;
      o.wall_angle = flt == wlsp_pkg::FAULT_OK ? ang[15:0] : '0;
      return o;
   endfunction

   // register mirror and expectation store
   always @(posedge clock) begin
      if (reset) begin
         min_mm = 30; max_mm = 1200; diff_mm = 500;
         far_l = -7000; near_l = -2000; far_r = 7000; near_r = 2000;
      end else begin
         if (csr_we) begin
            case (csr_index)
               wlsp_pkg::CSR_MIN_VALID:        min_mm = csr_wdata[14:0];
               wlsp_pkg::CSR_RELIABLE_RANGE:   max_mm = csr_wdata[14:0];
               wlsp_pkg::CSR_MAX_PAIR_DIFF:    diff_mm = csr_wdata[14:0];
               wlsp_pkg::CSR_FAR_ANGLE_LEFT:   far_l = $signed(csr_wdata);
               wlsp_pkg::CSR_NEAR_ANGLE_LEFT:  near_l = $signed(csr_wdata);
               wlsp_pkg::CSR_FAR_ANGLE_RIGHT:  far_r = $signed(csr_wdata);
               wlsp_pkg::CSR_NEAR_ANGLE_RIGHT: near_r = $signed(csr_wdata);
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready)
            wall_q.push_back(typed_on ? typed_rsp : wall_line(req_chan.payload));
      end
   end

   // result check
   always @(posedge clock) begin
      wlsp_pkg::rsp_payload_type e, g;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         g = rsp_chan.payload;
         if (wall_q.size() == 0) begin
            n_err++;
            if (n_err <= 10) $display("unexpected transfer: %p", g);
         end else begin
            e = wall_q.pop_front();
            if (g.side_out !== e.side_out || g.wall_valid !== e.wall_valid ||
                g.fault !== e.fault || g.wall_distance !== e.wall_distance ||
                g.wall_angle !== e.wall_angle) begin
               n_err++;
               if (n_err <= 10) $display("mismatch: expected %p got %p", e, g);
            end
         end
      end
   end

   // result-side stalls
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else if (no_idle) rsp_chan.ready <= 1'b1;
      else if (stall_cnt > 0) begin
         stall_cnt--;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_cnt = $urandom_range(0, 6);
         rsp_chan.ready <= 1'b0;
      end else rsp_chan.ready <= 1'b1;
   end

   task automatic send(wlsp_pkg::req_payload_type rq, bit typed, logic [1:0] flt);
      wlsp_pkg::rsp_payload_type t;
      t = '0;
      t.side_out = rq.side;
      t.fault = flt;
      req_chan.valid <= 1'b1;
      req_chan.payload <= rq;
      typed_on <= typed;
      typed_rsp <= t;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (wall_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic csr_write(logic [wlsp_pkg::CSR_INDEX_W-1:0] idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic dir_row_type item(int s, int unsigned f, int unsigned n, int typed = 0,
                                        logic [1:0] flt = wlsp_pkg::FAULT_OK);
      dir_row_type r;
      r = '{default: '0};
      r.req = '{side: s[0], far_reading: f[15:0], near_reading: n[15:0]};
      r.typed = typed[0];
      r.fault = flt;
      return r;
   endfunction

   function automatic dir_row_type reg_row(logic [wlsp_pkg::CSR_INDEX_W-1:0] idx, int v);
      dir_row_type r;
      r = '{default: '0};
      r.is_csr = 1'b1;
      r.idx = idx;
      r.val = v[15:0];
      return r;
   endfunction

   initial begin
      dir_row_type rows[$];
      wlsp_pkg::req_payload_type rq;
      int unsigned f, n, lo, hi, dmax;
      int off;
      reset = 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      typed_on <= 1'b0;
      typed_rsp <= '0;
      no_idle = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows = '{
         item(0, 0, 0, 1, wlsp_pkg::FAULT_RANGE),
         item(1, 65535, 65535, 1, wlsp_pkg::FAULT_RANGE),
         item(0, 29, 100, 1, wlsp_pkg::FAULT_RANGE),
         item(1, 100, 1201, 1, wlsp_pkg::FAULT_RANGE),
         item(0, 1200, 30, 1, wlsp_pkg::FAULT_DIFF),
         item(1, 30, 531, 1, wlsp_pkg::FAULT_DIFF),
         item(0, 30, 30), item(1, 1200, 1200), item(0, 530, 30), item(1, 800, 700),
         item(0, 300, 250),
         reg_row(wlsp_pkg::CSR_NEAR_ANGLE_LEFT, -7000),
         item(0, 500, 500, 1, wlsp_pkg::FAULT_COINCIDE), item(0, 600, 500),
         reg_row(wlsp_pkg::CSR_FAR_ANGLE_RIGHT, 18000),
         reg_row(wlsp_pkg::CSR_NEAR_ANGLE_RIGHT, -18000),
         item(1, 1000, 900),
         reg_row(wlsp_pkg::CSR_FAR_ANGLE_RIGHT, 9000),
         reg_row(wlsp_pkg::CSR_NEAR_ANGLE_RIGHT, -9000),
         item(1, 500, 400),
         reg_row(wlsp_pkg::CSR_MIN_VALID, 0), reg_row(wlsp_pkg::CSR_RELIABLE_RANGE, 32767),
         reg_row(wlsp_pkg::CSR_MAX_PAIR_DIFF, 32767),
         item(0, 0, 32767), item(1, 32767, 0),
         item(0, 0, 0, 1, wlsp_pkg::FAULT_COINCIDE),
         reg_row(wlsp_pkg::CSR_MIN_VALID, 2000), reg_row(wlsp_pkg::CSR_RELIABLE_RANGE, 100),
         item(0, 1000, 1000, 1, wlsp_pkg::FAULT_RANGE)
      };
      foreach (rows[i]) begin
         if (rows[i].is_csr) begin
            drain();
            csr_write(rows[i].idx, rows[i].val);
         end else send(rows[i].req, rows[i].typed, rows[i].fault);
      end

      for (int p = 0; p < 8; p++) begin
         drain();
         if (p == 0) begin
            csr_write(wlsp_pkg::CSR_MIN_VALID, 16'd0);
            csr_write(wlsp_pkg::CSR_RELIABLE_RANGE, 16'd32767);
            csr_write(wlsp_pkg::CSR_MAX_PAIR_DIFF, 16'd32767);
            csr_write(wlsp_pkg::CSR_FAR_ANGLE_LEFT, -16'sd18000);
            csr_write(wlsp_pkg::CSR_NEAR_ANGLE_LEFT, 16'sd18000);
            csr_write(wlsp_pkg::CSR_FAR_ANGLE_RIGHT, 16'h8000);
            csr_write(wlsp_pkg::CSR_NEAR_ANGLE_RIGHT, 16'h7FFF);
         end else begin
            csr_write(wlsp_pkg::CSR_MIN_VALID, 16'(p == 3 ? $urandom_range(2000, 32767)
                                                          : $urandom_range(0, 600)));
            csr_write(wlsp_pkg::CSR_RELIABLE_RANGE, 16'(p == 3 ? $urandom_range(0, 1999)
                                                               : $urandom_range(200, 32767)));
            csr_write(wlsp_pkg::CSR_MAX_PAIR_DIFF, 16'(p == 5 ? $urandom()
                                                              : $urandom_range(0, 32767)));
            csr_write(wlsp_pkg::CSR_FAR_ANGLE_LEFT, 16'($urandom_range(0, 36000) - 18000));
            csr_write(wlsp_pkg::CSR_NEAR_ANGLE_LEFT, 16'($urandom_range(0, 36000) - 18000));
            csr_write(wlsp_pkg::CSR_FAR_ANGLE_RIGHT,
                      16'(p == 6 ? $urandom() : $urandom_range(0, 36000) - 18000));
            csr_write(wlsp_pkg::CSR_NEAR_ANGLE_RIGHT, 16'($urandom_range(0, 36000) - 18000));
         end
         if (p == 7) no_idle = 1;
         lo = min_mm;
         hi = max_mm;
         dmax = diff_mm;
         for (int k = 0; k < 200; k++) begin
            if (lo <= hi && $urandom_range(0, 9) < 8) begin
               f = $urandom_range(lo, hi);
               off = $urandom_range(0, (dmax > 20000 ? 20000 : dmax) + 20);
               n = $urandom_range(0, 1) ? f + off : (f > off ? f - off : 0);
               if (n > 65535) n = 65535;
            end else begin
               f = $urandom_range(0, 65535);
               n = $urandom_range(0, 65535);
            end
            rq.side = 1'($urandom_range(0, 1));
            rq.far_reading = f[15:0];
            rq.near_reading = n[15:0];
            send(rq, 1'b0, wlsp_pkg::FAULT_OK);
         end
      end

      drain();
      repeat (100) @(posedge clock);
      if (n_err == 0 && wall_q.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
